/* hw/rtl/cpt_pkg.sv */
// Shared constants and types for the Clarke/Park transform pipeline.
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    // Default sample width and the fixed angle width (Q14 cosine and sine).
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int ANGLE_WIDTH          = 16;

    // Q15 constants.
    localparam logic signed [15:0] K_INV_SQRT3     = 16'sd18919;  // 1/sqrt(3)
    localparam logic signed [16:0] K_TWO_INV_SQRT3 = 17'sd37838;  // 2/sqrt(3)
    localparam logic signed [15:0] K_SQRT3_HALF    = 16'sd28378;  // sqrt(3)/2

    // Operation codes.
    typedef enum logic [0:0] {
        OP_FORWARD = 1'b0,   // phases to d/q
        OP_INVERSE = 1'b1    // d/q to phases
    } op_t;

endpackage

`default_nettype wire

/* hw/rtl/clarke_park_transform_top.sv */
// Clarke/Park transform: five-stage pipeline with valid/ready channels.
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle unless stalled; stages multiply, add, or both.
// A stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled output still lets upstream stages fill.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers keep
// whatever they held.
module clarke_park_transform_top #(
    parameter int SAMPLE_WIDTH = cpt_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic                           s_opcode,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_first_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_second_in,
    input  wire logic signed [cpt_pkg::ANGLE_WIDTH-1:0] s_cos_angle,
    input  wire logic signed [cpt_pkg::ANGLE_WIDTH-1:0] s_sin_angle,
    // result channel
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic signed [SAMPLE_WIDTH-1:0] m_first_out,
    output      logic signed [SAMPLE_WIDTH-1:0] m_second_out,
    output      logic signed [SAMPLE_WIDTH-1:0] m_third_out,
    output      logic                           m_saturated
);
    import cpt_pkg::*;

    // ------------------------------------------------------------------
    // Widths, all derived from SAMPLE_WIDTH
    // ------------------------------------------------------------------
    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = ANGLE_WIDTH;
    localparam int NW   = AW + 1;        // sine, possibly negated
    localparam int VW   = SW + 1;        // Clarke y reaches about 1.73 full scale
    localparam int CW   = SW + 18;       // Clarke sum
    localparam int PW   = NW + VW;       // rotation products
    localparam int SUMW = PW + 1;        // rotation sums
    localparam int RW   = SUMW - 14;     // rotated values after the Q14 shift
    localparam int MW   = RW + 16;       // phase-spread products
    localparam int EW   = MW + 1 - 15;   // phase values before saturation

    localparam logic signed [CW-1:0]   RND15_C = {{(CW-15){1'b0}}, 1'b1, 14'b0};
    localparam logic signed [SUMW-1:0] RND14_S = {{(SUMW-14){1'b0}}, 1'b1, 13'b0};
    localparam logic signed [MW:0]     RND15_M = {{(MW-14){1'b0}}, 1'b1, 14'b0};

    localparam logic signed [EW-1:0] SAT_MAX = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_MIN = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    // Clip to the sample range; the top bit of the result is the clip flag.
    function automatic logic [SW:0] sat_pack(input logic signed [EW-1:0] v);
        logic [SW:0] r;
        if (v > SAT_MAX) begin
            r = {1'b1, SAT_MAX[SW-1:0]};
        end else if (v < SAT_MIN) begin
            r = {1'b1, SAT_MIN[SW-1:0]};
        end else begin
            r = {1'b0, v[SW-1:0]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake: each stage advances when empty or when the next advances
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = v5_reg;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg  : v2_reg;
    assign v3_next = en3 ? v2_reg  : v3_reg;
    assign v4_next = en4 ? v3_reg  : v4_reg;
    assign v5_next = en5 ? v4_reg  : v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: Clarke y for forward items, operand setup.
    // Both directions share one rotation form:
    //   o0 = cos*u + n*v,  o1 = cos*v - n*u
    // with n = sin (forward, u = a, v = y) or n = -sin (inverse, u = d, v = q).
    // ------------------------------------------------------------------
    op_t                   op1_reg, op1_next;
    logic signed [SW-1:0]  u1_reg,  u1_next;
    logic signed [VW-1:0]  w1_reg,  w1_next;
    logic signed [AW-1:0]  c1_reg,  c1_next;
    logic signed [NW-1:0]  n1_reg,  n1_next;

    logic signed [CW-1:0]  clarke_sum;
    logic signed [CW-1:0]  clarke_rnd;

    always_comb begin
        op1_next   = op_t'(s_opcode);
        clarke_sum = CW'(K_INV_SQRT3) * CW'(s_first_in)
                   + CW'(K_TWO_INV_SQRT3) * CW'(s_second_in);
        clarke_rnd = clarke_sum + RND15_C;
        u1_next    = s_first_in;
        c1_next    = s_cos_angle;
        if (op1_next == OP_INVERSE) begin
            w1_next = VW'(s_second_in);
            n1_next = -NW'(s_sin_angle);
        end else begin
            w1_next = clarke_rnd[VW+14:15];
            n1_next = NW'(s_sin_angle);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg <= op1_next;
            u1_reg  <= u1_next;
            w1_reg  <= w1_next;
            c1_reg  <= c1_next;
            n1_reg  <= n1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four rotation products
    // ------------------------------------------------------------------
    op_t                  op2_reg, op2_next;
    logic signed [PW-1:0] pcu_reg, pcu_next;
    logic signed [PW-1:0] pnw_reg, pnw_next;
    logic signed [PW-1:0] pcw_reg, pcw_next;
    logic signed [PW-1:0] pnu_reg, pnu_next;

    always_comb begin
        op2_next = op1_reg;
        pcu_next = PW'(c1_reg) * PW'(u1_reg);
        pnw_next = PW'(n1_reg) * PW'(w1_reg);
        pcw_next = PW'(c1_reg) * PW'(w1_reg);
        pnu_next = PW'(n1_reg) * PW'(u1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg <= op2_next;
            pcu_reg <= pcu_next;
            pnw_reg <= pnw_next;
            pcw_reg <= pcw_next;
            pnu_reg <= pnu_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums with Q14 rounding
    // ------------------------------------------------------------------
    op_t                    op3_reg, op3_next;
    logic signed [RW-1:0]   r0_3_reg, r0_3_next;
    logic signed [RW-1:0]   r1_3_reg, r1_3_next;
    logic signed [SUMW-1:0] sum0, sum1;

    always_comb begin
        op3_next  = op2_reg;
        sum0      = SUMW'(pcu_reg) + SUMW'(pnw_reg) + RND14_S;
        sum1      = SUMW'(pcw_reg) - SUMW'(pnu_reg) + RND14_S;
        r0_3_next = sum0[SUMW-1:14];
        r1_3_next = sum1[SUMW-1:14];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            op3_reg  <= op3_next;
            r0_3_reg <= r0_3_next;
            r1_3_reg <= r1_3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: phase-spread products -x/2 and (sqrt3/2)*y, both Q15
    // ------------------------------------------------------------------
    op_t                  op4_reg, op4_next;
    logic signed [RW-1:0] r0_4_reg, r0_4_next;
    logic signed [RW-1:0] r1_4_reg, r1_4_next;
    logic signed [MW-1:0] mx_reg, mx_next;
    logic signed [MW-1:0] my_reg, my_next;

    always_comb begin
        op4_next  = op3_reg;
        r0_4_next = r0_3_reg;
        r1_4_next = r1_3_reg;
        mx_next   = -(MW'(r0_3_reg) <<< 14);
        my_next   = MW'(K_SQRT3_HALF) * MW'(r1_3_reg);
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            op4_reg  <= op4_next;
            r0_4_reg <= r0_4_next;
            r1_4_reg <= r1_4_next;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Q15 rounding of phases b and c, saturation, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] o0_reg, o0_next;
    logic signed [SW-1:0] o1_reg, o1_next;
    logic signed [SW-1:0] o2_reg, o2_next;
    logic                 sat_reg, sat_next;

    logic signed [MW:0]   sum_b, sum_c;
    logic signed [EW-1:0] pb, pc;
    logic [SW:0]          s0, s1, s2, sb, sc;

    always_comb begin
        sum_b = (MW+1)'(mx_reg) + (MW+1)'(my_reg) + RND15_M;
        sum_c = (MW+1)'(mx_reg) - (MW+1)'(my_reg) + RND15_M;
        pb    = sum_b[MW:15];
        pc    = sum_c[MW:15];
        s0    = sat_pack(EW'(r0_4_reg));
        s1    = sat_pack(EW'(r1_4_reg));
        sb    = sat_pack(pb);
        sc    = sat_pack(pc);
        if (op4_reg == OP_INVERSE) begin
            s2 = sc;
            o1_next = sb[SW-1:0];
            sat_next = s0[SW] | sb[SW] | sc[SW];
        end else begin
            // forward: third output is zero and never clips
            s2 = '0;
            o1_next = s1[SW-1:0];
            sat_next = s0[SW] | s1[SW];
        end
        o0_next = s0[SW-1:0];
        o2_next = s2[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            o0_reg  <= o0_next;
            o1_reg  <= o1_next;
            o2_reg  <= o2_next;
            sat_reg <= sat_next;
        end
    end

    assign m_first_out  = o0_reg;
    assign m_second_out = o1_reg;
    assign m_third_out  = o2_reg;
    assign m_saturated  = sat_reg;

endmodule

`default_nettype wire
